// ===== src/pcct_pkg.sv =====
// ----------------------------------------------------------------------------
// pcct_pkg: shared types and constants of the per-CPU compare timer
// Field widths, item modes, register selects and MMIO offsets.
// ----------------------------------------------------------------------------
package pcct_pkg;

    localparam int MAX_CPUS_DEF = 4;

    localparam int MODE_W   = 3;
    localparam int CPU_W    = 2;
    localparam int REGSEL_W = 2;
    localparam int OFFSET_W = 8;
    localparam int SIZE_W   = 4;
    localparam int DATA_W   = 64;
    localparam int LINES_W  = 4;
    localparam int CFG_W    = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK       = 3'd0,
        MODE_MMIO_READ  = 3'd1,
        MODE_MMIO_WRITE = 3'd2,
        MODE_SYS_READ   = 3'd3,
        MODE_SYS_WRITE  = 3'd4,
        MODE_CLEAR_IRQ  = 3'd5
    } t_mode;

    typedef enum logic [REGSEL_W-1:0] {
        REG_CTL  = 2'd0,
        REG_CVAL = 2'd1,
        REG_TVAL = 2'd2
    } t_reg_sel;

    localparam logic [OFFSET_W-1:0] OFF_COUNT   = 8'h00;
    localparam logic [OFFSET_W-1:0] OFF_COMPARE = 8'h08;
    localparam logic [OFFSET_W-1:0] OFF_CONTROL = 8'h10;

    localparam logic [SIZE_W-1:0] SIZE_WORD  = 4'd4;
    localparam logic [SIZE_W-1:0] SIZE_DWORD = 4'd8;

endpackage

// ===== src/pcct_if.sv =====
// ----------------------------------------------------------------------------
// pcct interfaces: item and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface pcct_in_if;
    logic                            valid;
    logic                            ready;
    logic [pcct_pkg::MODE_W-1:0]     mode;
    logic [pcct_pkg::CPU_W-1:0]      cpu_id;
    logic                            channel_select;
    logic [pcct_pkg::REGSEL_W-1:0]   register_select;
    logic [pcct_pkg::OFFSET_W-1:0]   mmio_offset;
    logic [pcct_pkg::SIZE_W-1:0]     access_size;
    logic [pcct_pkg::DATA_W-1:0]     value;

    modport source (
        output valid, mode, cpu_id, channel_select, register_select,
               mmio_offset, access_size, value,
        input  ready
    );
    modport sink (
        input  valid, mode, cpu_id, channel_select, register_select,
               mmio_offset, access_size, value,
        output ready
    );
endinterface

interface pcct_out_if;
    logic                            valid;
    logic                            ready;
    logic [pcct_pkg::DATA_W-1:0]     read_data;
    logic                            mmio_irq;
    logic [pcct_pkg::LINES_W-1:0]    virtual_irq_lines;
    logic [pcct_pkg::LINES_W-1:0]    physical_irq_lines;

    modport source (
        output valid, read_data, mmio_irq, virtual_irq_lines, physical_irq_lines,
        input  ready
    );
    modport sink (
        input  valid, read_data, mmio_irq, virtual_irq_lines, physical_irq_lines,
        output ready
    );
endinterface

// ===== src/per_cpu_compare_timer_top.sv =====
// ----------------------------------------------------------------------------
// per_cpu_compare_timer_top: 64-bit count, MMIO compare timer, per-CPU channels
// Result: registered; the result of an item is valid in the cycle after its transfer.
// Throughput: one item per cycle; the result register frees in the same cycle
//   it is drained, so input ready is low only while a result waits unread.
// Reset: synchronous, active low; count, compares, flags and control clear,
//   and one CPU is active.
// ----------------------------------------------------------------------------
module per_cpu_compare_timer_top #(
    parameter int MAX_CPUS = pcct_pkg::MAX_CPUS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pcct_in_if.sink                       i_item,
    pcct_out_if.source                    o_result,
    input  logic                          i_cfg_wr_en,
    input  logic [pcct_pkg::CFG_W-1:0]    i_cfg_wr_data
);

    // Two channels per CPU: virtual at even index, physical at odd index.
    localparam int CH_N = 2 * MAX_CPUS;
    localparam int DW   = pcct_pkg::DATA_W;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [pcct_pkg::CFG_W-1:0] r_cpus;
    logic [DW-1:0]              r_count;
    logic [DW-1:0]              r_mmio_compare;
    logic                       r_mmio_enable;
    logic                       r_mmio_pending;
    logic                       r_mmio_fired;
    logic [DW-1:0]              r_chan_compare [CH_N];
    logic [CH_N-1:0]            r_chan_enable;
    logic [CH_N-1:0]            r_chan_mask;
    logic [CH_N-1:0]            r_chan_pending;

    // Result register
    logic                       r_out_valid;
    logic [DW-1:0]              r_out_read_data;
    logic                       r_out_mmio_irq;
    logic [pcct_pkg::LINES_W-1:0] r_out_virt;
    logic [pcct_pkg::LINES_W-1:0] r_out_phys;

    // Next values
    logic [DW-1:0]              n_count;
    logic [DW-1:0]              n_mmio_compare;
    logic                       n_mmio_enable;
    logic                       n_mmio_pending;
    logic                       n_mmio_fired;
    logic [DW-1:0]              n_chan_compare [CH_N];
    logic [CH_N-1:0]            n_chan_enable;
    logic [CH_N-1:0]            n_chan_mask;
    logic [CH_N-1:0]            n_chan_pending;
    logic [DW-1:0]              n_read_data;
    logic [pcct_pkg::LINES_W-1:0] n_virt;
    logic [pcct_pkg::LINES_W-1:0] n_phys;

    logic                       w_accept;
    logic [pcct_pkg::CFG_W-1:0] w_active;
    logic [CH_N-1:0]            w_act_mask;
    logic [CH_N-1:0]            w_new_act_mask;
    logic [pcct_pkg::CPU_W-1:0] w_cpu;
    logic [CH_N-1:0]            w_sel;
    logic                       w_size_ok;
    logic                       w_update;
    logic                       w_sel_enable;
    logic                       w_sel_mask;
    logic [DW-1:0]              w_sel_compare;
    logic [DW-1:0]              w_tval_ext;

    // Clamp the configured CPU count into 1..MAX_CPUS.
    function automatic logic [pcct_pkg::CFG_W-1:0] clamp_cpus(
        input logic [pcct_pkg::CFG_W-1:0] cfg
    );
        logic [pcct_pkg::CFG_W-1:0] n;
        n = cfg;
        if (cfg == '0) begin
            n = pcct_pkg::CFG_W'(1);
        end else if (32'(cfg) > MAX_CPUS) begin
            n = pcct_pkg::CFG_W'(MAX_CPUS);
        end
        return n;
    endfunction

    // Channels that belong to the first n CPUs.
    function automatic logic [CH_N-1:0] chan_active(
        input logic [pcct_pkg::CFG_W-1:0] n
    );
        logic [CH_N-1:0] m;
        for (int j = 0; j < CH_N; j++) begin
            m[j] = (2 * 32'(n)) > j;
        end
        return m;
    endfunction

    assign w_accept       = i_item.valid && i_item.ready;
    assign i_item.ready   = !r_out_valid || o_result.ready;
    assign w_active       = clamp_cpus(r_cpus);
    assign w_act_mask     = chan_active(w_active);
    assign w_new_act_mask = chan_active(clamp_cpus(i_cfg_wr_data));
    assign w_size_ok      = (i_item.access_size == pcct_pkg::SIZE_WORD) ||
                            (i_item.access_size == pcct_pkg::SIZE_DWORD);
    assign w_tval_ext     = {{32{i_item.value[31]}}, i_item.value[31:0]};

    // Out-of-range CPU indexes land on the last active CPU.
    always_comb begin
        if (pcct_pkg::CFG_W'(i_item.cpu_id) >= w_active) begin
            w_cpu = pcct_pkg::CPU_W'(w_active - pcct_pkg::CFG_W'(1));
        end else begin
            w_cpu = i_item.cpu_id;
        end
    end

    // One-hot channel select and the addressed channel's fields.
    always_comb begin
        w_sel_enable  = 1'b0;
        w_sel_mask    = 1'b0;
        w_sel_compare = '0;
        for (int j = 0; j < CH_N; j++) begin
            w_sel[j] = 32'({w_cpu, i_item.channel_select}) == j;
            if (w_sel[j]) begin
                w_sel_enable  = r_chan_enable[j];
                w_sel_mask    = r_chan_mask[j];
                w_sel_compare = r_chan_compare[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Item decode and state update: one pass per transfer
    // ------------------------------------------------------------------
    always_comb begin
        n_count        = r_count;
        n_mmio_compare = r_mmio_compare;
        n_mmio_enable  = r_mmio_enable;
        n_mmio_pending = r_mmio_pending;
        n_mmio_fired   = r_mmio_fired;
        n_chan_compare = r_chan_compare;
        n_chan_enable  = r_chan_enable;
        n_chan_mask    = r_chan_mask;
        n_chan_pending = r_chan_pending;
        n_read_data    = '0;
        w_update       = 1'b0;

        unique case (pcct_pkg::t_mode'(i_item.mode))
            pcct_pkg::MODE_TICK: begin
                // advance the count, wrapping
                n_count  = r_count + i_item.value;
                w_update = 1'b1;
            end
            pcct_pkg::MODE_MMIO_READ: begin
                if (w_size_ok) begin
                    priority if (i_item.mmio_offset == pcct_pkg::OFF_COUNT) begin
                        n_read_data = r_count;
                    end else if (i_item.mmio_offset == pcct_pkg::OFF_COMPARE) begin
                        n_read_data = r_mmio_compare;
                    end else if (i_item.mmio_offset == pcct_pkg::OFF_CONTROL) begin
                        n_read_data = {62'd0, r_mmio_pending, r_mmio_enable};
                    end else begin
                        n_read_data = '0;
                    end
                end
            end
            pcct_pkg::MODE_MMIO_WRITE: begin
                if (w_size_ok && i_item.mmio_offset == pcct_pkg::OFF_COMPARE) begin
                    n_mmio_compare = i_item.value;
                    n_mmio_pending = 1'b0;
                    n_mmio_fired   = 1'b0;
                    w_update       = 1'b1;
                end else if (w_size_ok && i_item.mmio_offset == pcct_pkg::OFF_CONTROL) begin
                    n_mmio_enable = i_item.value[0];
                    if (!i_item.value[0]) begin
                        n_mmio_pending = 1'b0;
                        n_mmio_fired   = 1'b0;
                    end
                    if (i_item.value[1]) begin
                        n_mmio_pending = 1'b0;
                    end
                    w_update = 1'b1;
                end
            end
            pcct_pkg::MODE_SYS_READ: begin
                unique case (pcct_pkg::t_reg_sel'(i_item.register_select))
                    pcct_pkg::REG_CTL: begin
                        n_read_data = {61'd0,
                                       w_sel_enable && (r_count >= w_sel_compare),
                                       w_sel_mask, w_sel_enable};
                    end
                    pcct_pkg::REG_CVAL: begin
                        n_read_data = w_sel_compare;
                    end
                    pcct_pkg::REG_TVAL: begin
                        n_read_data = {32'd0, 32'(w_sel_compare - r_count)};
                    end
                    default: begin
                        n_read_data = '0;
                    end
                endcase
            end
            pcct_pkg::MODE_SYS_WRITE: begin
                for (int j = 0; j < CH_N; j++) begin
                    if (w_sel[j]) begin
                        unique case (pcct_pkg::t_reg_sel'(i_item.register_select))
                            pcct_pkg::REG_CTL: begin
                                n_chan_enable[j] = i_item.value[0];
                                n_chan_mask[j]   = i_item.value[1];
                            end
                            pcct_pkg::REG_CVAL: begin
                                n_chan_compare[j] = i_item.value;
                            end
                            pcct_pkg::REG_TVAL: begin
                                n_chan_compare[j] = r_count + w_tval_ext;
                            end
                            default: begin
                                n_chan_compare[j] = r_chan_compare[j];
                            end
                        endcase
                    end
                end
                w_update = (i_item.register_select == pcct_pkg::REG_CTL) ||
                           (i_item.register_select == pcct_pkg::REG_CVAL) ||
                           (i_item.register_select == pcct_pkg::REG_TVAL);
            end
            pcct_pkg::MODE_CLEAR_IRQ: begin
                // drop the level until the next recompute
                n_chan_pending = r_chan_pending & ~w_sel;
            end
            default: begin
                n_read_data = '0;
            end
        endcase

        // Recompute levels after ticks and writes.
        if (w_update) begin
            if (n_mmio_enable && !n_mmio_pending && !n_mmio_fired &&
                (n_count >= n_mmio_compare)) begin
                n_mmio_pending = 1'b1;
                n_mmio_fired   = 1'b1;
            end
            for (int j = 0; j < CH_N; j++) begin
                if (w_act_mask[j]) begin
                    n_chan_pending[j] = n_chan_enable[j] && !n_chan_mask[j] &&
                                        (n_count >= n_chan_compare[j]);
                end
            end
        end
    end

    // Interrupt lines for the first four CPUs, masked to active ones.
    for (genvar g = 0; g < pcct_pkg::LINES_W; g++) begin : g_lines
        if (g < MAX_CPUS) begin : g_used
            assign n_virt[g] = n_chan_pending[2*g]     && w_act_mask[2*g];
            assign n_phys[g] = n_chan_pending[2*g + 1] && w_act_mask[2*g + 1];
        end else begin : g_unused
            assign n_virt[g] = 1'b0;
            assign n_phys[g] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpus         <= pcct_pkg::CFG_W'(1);
            r_count        <= '0;
            r_mmio_compare <= '0;
            r_mmio_enable  <= 1'b0;
            r_mmio_pending <= 1'b0;
            r_mmio_fired   <= 1'b0;
            r_chan_enable  <= '0;
            r_chan_mask    <= '0;
            r_chan_pending <= '0;
            for (int j = 0; j < CH_N; j++) begin
                r_chan_compare[j] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            // zero the channels of CPUs that drop out
            r_cpus         <= i_cfg_wr_data;
            r_chan_enable  <= r_chan_enable  & w_new_act_mask;
            r_chan_mask    <= r_chan_mask    & w_new_act_mask;
            r_chan_pending <= r_chan_pending & w_new_act_mask;
            for (int j = 0; j < CH_N; j++) begin
                if (!w_new_act_mask[j]) begin
                    r_chan_compare[j] <= '0;
                end
            end
        end else if (w_accept) begin
            r_count        <= n_count;
            r_mmio_compare <= n_mmio_compare;
            r_mmio_enable  <= n_mmio_enable;
            r_mmio_pending <= n_mmio_pending;
            r_mmio_fired   <= n_mmio_fired;
            r_chan_compare <= n_chan_compare;
            r_chan_enable  <= n_chan_enable;
            r_chan_mask    <= n_chan_mask;
            r_chan_pending <= n_chan_pending;
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on transfer, hold until taken
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_read_data <= n_read_data;
            r_out_mmio_irq  <= n_mmio_pending;
            r_out_virt      <= n_virt;
            r_out_phys      <= n_phys;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.read_data          = r_out_read_data;
    assign o_result.mmio_irq           = r_out_mmio_irq;
    assign o_result.virtual_irq_lines  = r_out_virt;
    assign o_result.physical_irq_lines = r_out_phys;

`ifndef SYNTHESIS
    // MMIO pending only ever rises together with the one-shot mark.
    a_pending_has_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mmio_pending |-> r_mmio_fired)
        else $error("mmio pending without fired mark");

    // Channels of inactive CPUs never carry a pending level.
    a_inactive_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chan_pending & ~w_act_mask) == '0)
        else $error("pending level on an inactive channel");

    // A stalled result blocks new items, so the count holds.
    a_stall_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> $stable(r_count))
        else $error("count moved while the result was stalled");
`endif

endmodule
